// ===== src/pfd_pkg.sv =====
// Shared types and constants for the pixel format decoder.
// Holds the format codes and the ARGB colour struct; no dependencies.
package pfd_pkg;

  typedef enum logic [3:0] {
    FMT_1BPP     = 4'd0,
    FMT_4BPP     = 4'd1,
    FMT_8BPP     = 4'd2,
    FMT_ARGB1555 = 4'd3,
    FMT_GRAY16   = 4'd4,
    FMT_RGB555   = 4'd5,
    FMT_RGB565   = 4'd6,
    FMT_RGB24    = 4'd7,
    FMT_ARGB32   = 4'd8
  } fmt_e;

  localparam logic [3:0] FMT_RESET = FMT_ARGB32;

  localparam logic REQ_PAL_WRITE = 1'b0;
  localparam logic REQ_DECODE    = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } argb_t;

endpackage

// ===== src/pixel_format_decoder_with_palette_unit.sv =====
// Top level of the pixel format decoder with palette.
// Depends on pfd_pkg for format codes and the ARGB struct.
//
// Usage
// -----
// The input channel (in_valid_i / in_stall_o) carries one item per handshake:
// either a palette write (req_type_i = 0) that stores palette_color_i at
// palette_index_i, or a pixel decode (req_type_i = 1) that turns
// pixel_bytes_i and pixel_column_i into 8-bit alpha, red, green and blue.
// Only decodes produce a result item on the output channel
// (out_valid_o / out_stall_i). The storage format comes from the single
// configuration register, written over cfg_valid_i / cfg_ready_o; cfg_ready_o
// is always high. The user must write it only while the block is idle, not enforced.
//
// A decode item, once accepted, first reads the palette memory (its read port
// is registered) and forms the direct colour, then selects and registers the
// result in the output register. One item is accepted every cycle while
// in_stall_o is low; the palette memory has one write and one read port,
// so a write and a decode never compete. When the receiver stalls, the
// output register holds its item, the stage behind it holds too, and
// in_stall_o rises only once both stages are full.
// Reset empties the pipeline, sets the format to 32-bit ARGB and clears the
// palette valid bits, so every entry reads as zero until written; the memory
// itself needs no clearing pass.
module pixel_format_decoder_with_palette_unit
  import pfd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] pixel_bytes_i,
  input  logic [2:0]  pixel_column_i,
  input  logic [7:0]  palette_index_i,
  input  logic [31:0] palette_color_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  alpha_out_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Configuration register.
  logic [3:0] fmt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RESET;
    end else if (cfg_valid_i) begin
      fmt_q <= cfg_data_i;
    end
  end

  // Pipeline handshake.
  logic s1_valid_q;
  logic out_valid_q;
  logic out_ready;
  logic s1_ready;
  logic in_acc;
  logic dec_acc;
  logic wr_acc;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;
  assign dec_acc    = in_acc && (req_type_i == REQ_DECODE);
  assign wr_acc     = in_acc && (req_type_i == REQ_PAL_WRITE);

  // Stage 0: palette index and direct colour from the input item.
  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] word;
  logic [7:0]  pal_idx;
  logic        use_pal;
  argb_t       direct;

  assign b0   = pixel_bytes_i[7:0];
  assign b1   = pixel_bytes_i[15:8];
  assign b2   = pixel_bytes_i[23:16];
  assign b3   = pixel_bytes_i[31:24];
  assign word = pixel_bytes_i[15:0];

  always_comb begin
    pal_idx = 8'd0;
    use_pal = 1'b0;
    direct  = '0;
    unique case (fmt_q)
      FMT_1BPP: begin
        use_pal = 1'b1;
        pal_idx = {7'd0, b0[3'd7 - pixel_column_i]};
      end
      FMT_4BPP: begin
        use_pal = 1'b1;
        pal_idx = pixel_column_i[0] ? {4'd0, b0[3:0]} : {4'd0, b0[7:4]};
      end
      FMT_8BPP: begin
        use_pal = 1'b1;
        pal_idx = b0;
      end
      FMT_ARGB1555: begin
        direct = '{a: {7'd0, b0[0]}, r: {3'd0, word[15:11]},
                   g: {3'd0, word[10:6]}, b: {3'd0, b0[5:1]}};
      end
      FMT_RGB555: begin
        direct = '{a: ALPHA_OPAQUE, r: {3'd0, word[15:11]},
                   g: {3'd0, word[10:6]}, b: {3'd0, b0[5:1]}};
      end
      FMT_RGB565: begin
        direct = '{a: ALPHA_OPAQUE, r: {word[15:11], 3'd0},
                   g: {word[10:5], 2'd0}, b: {word[4:0], 3'd0}};
      end
      FMT_RGB24: begin
        direct = '{a: ALPHA_OPAQUE, r: b2, g: b1, b: b0};
      end
      FMT_ARGB32: begin
        direct = '{a: b3, r: b2, g: b1, b: b0};
      end
      default: begin
        // Grayscale and unassigned codes decode to all zeros.
        direct = '0;
      end
    endcase
  end

  // Palette memory with per-entry valid bits, so unwritten entries read zero.
  logic [31:0]              pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_vld_q;
  logic                     rd_in_range;
  logic                     wr_in_range;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;

  assign rd_in_range = {1'b0, pal_idx} < 9'(PALETTE_DEPTH);
  assign wr_in_range = {1'b0, palette_index_i} < 9'(PALETTE_DEPTH);
  assign rd_addr     = pal_idx[AW-1:0];
  assign wr_addr     = palette_index_i[AW-1:0];

  logic [31:0] s1_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_acc && wr_in_range) begin
      pal_mem[wr_addr] <= palette_color_i;
    end
    if (dec_acc) begin
      s1_rd_q <= pal_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
    end else if (wr_acc && wr_in_range) begin
      pal_vld_q[wr_addr] <= 1'b1;
    end
  end

  // Stage 1 registers.
  logic  s1_use_pal_q;
  logic  s1_hit_q;
  argb_t s1_direct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= dec_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_acc) begin
      s1_use_pal_q <= use_pal;
      s1_hit_q     <= rd_in_range && pal_vld_q[rd_addr];
      s1_direct_q  <= direct;
    end
  end

  // Stage 2: choose palette or direct colour into the output register.
  argb_t res_d;
  argb_t res_q;

  always_comb begin
    if (s1_use_pal_q) begin
      res_d = s1_hit_q ? argb_t'(s1_rd_q) : '0;
    end else begin
      res_d = s1_direct_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign alpha_out_o = res_q.a;
  assign red_out_o   = res_q.r;
  assign green_out_o = res_q.g;
  assign blue_out_o  = res_q.b;

  // Assertions.
  a_empty_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // An unwritten entry may hold unknown bits, so the hold is compared exactly.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_ready) |=> (s1_valid_q && (s1_rd_q === $past(s1_rd_q))))
    else $error("first stage lost its palette read under stall");

  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_acc |=> !s1_valid_q)
    else $error("palette write produced a pending result");

  a_decode_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_acc |=> s1_valid_q)
    else $error("accepted decode item did not enter the first stage");

  a_out_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after being taken");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pixel_format_decoder_with_palette_unit.
// Depends on pfd_pkg for the format codes, request codes and the ARGB struct.
module testbench;
  import pfd_pkg::*;

  localparam int PAL_DEPTH    = 256;
  // Two register stages inside the block; DRAIN_CYCLES is the wait before
  // touching the format register or ending the run.
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int STALL_LIMIT  = 2000;

  // One pending request for the input channel: either a palette write or a
  // pixel decode, with all five fields carried regardless of kind.
  typedef struct {
    logic        req;
    logic [31:0] bytes;
    logic [2:0]  col;
    logic [7:0]  idx;
    logic [31:0] colour;
  } pixel_req_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i      = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic        req_type_i      = REQ_DECODE;
  logic [31:0] pixel_bytes_i   = '0;
  logic [2:0]  pixel_column_i  = '0;
  logic [7:0]  palette_index_i = '0;
  logic [31:0] palette_color_i = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [7:0]  alpha_out_o;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;

  // Requests waiting to be offered, and the colours that the accepted
  // decodes should produce, oldest first.
  pixel_req_t  pending_q[$];
  argb_t       colour_q[$];

  // Our own copy of the block's state: the palette and the current format.
  logic [31:0] pal_mem [PAL_DEPTH];
  logic [3:0]  fmt_cfg;

  int          errors        = 0;
  int          idle_cycles   = 0;

  // Traffic shaping, set by the stimulus process between phases.
  logic        eager         = 1'b0;  // sender offers back to back
  logic [1:0]  rx_mode       = 2'd0;  // receiver stall pattern
  int          hold_req_cnt  = 0;     // bumped to request one long hold-off

  int          burst_left    = 0;
  int          gap_left      = 0;
  int          hold_seen     = 0;
  int          hold_left     = 0;
  logic [7:0]  stall_pat     = 8'b1100_1010;

  pixel_format_decoder_with_palette_unit #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .pixel_bytes_i  (pixel_bytes_i),
    .pixel_column_i (pixel_column_i),
    .palette_index_i(palette_index_i),
    .palette_color_i(palette_color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alpha_out_o    (alpha_out_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Colour prediction
  // ---------------------------------------------------------------------

  // An index past the end of the palette reads as transparent black.
  function automatic argb_t palette_entry(input logic [7:0] idx);
    if (int'(idx) < PAL_DEPTH) begin
      return pal_mem[idx];
    end
    return '0;
  endfunction

  // Works out the colour a decode gives under the current format. The
  // 16-bit word is the low two bytes, little-endian. Grayscale 16 and the
  // unassigned format codes give all zeros.
  function automatic argb_t decode_pixel(input logic [31:0] bytes, input logic [2:0] col);
    argb_t       c;
    logic [7:0]  b0;
    logic [15:0] word;
    b0   = bytes[7:0];
    word = bytes[15:0];
    c    = '0;
    case (fmt_cfg)
      FMT_1BPP: c = palette_entry({7'd0, b0[3'd7 - col]});
      // Even columns take the high nibble, odd columns the low one.
      FMT_4BPP: c = palette_entry(col[0] ? {4'h0, b0[3:0]} : {4'h0, b0[7:4]});
      FMT_8BPP: c = palette_entry(b0);
      // The 5-bit components and the 1-bit alpha are passed through unscaled.
      FMT_ARGB1555: c = {{7'd0, b0[0]}, {3'd0, word[15:11]}, {3'd0, word[10:6]},
                         {3'd0, b0[5:1]}};
      FMT_RGB555: c = {ALPHA_OPAQUE, {3'd0, word[15:11]}, {3'd0, word[10:6]},
                       {3'd0, b0[5:1]}};
      FMT_RGB565: c = {ALPHA_OPAQUE, {word[15:11], 3'd0}, {word[10:5], 2'd0},
                       {word[4:0], 3'd0}};
      FMT_RGB24:  c = {ALPHA_OPAQUE, bytes[23:16], bytes[15:8], b0};
      FMT_ARGB32: c = bytes;
      default:    c = '0;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: takes requests from pending_q, works in bursts with
  // random gaps, and updates the prediction on each accepted item.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    pixel_req_t nxt;
    logic       offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      // An item is taken when valid is high and stall low at this edge.
      if (in_valid_i && !in_stall_o) begin
        if (req_type_i == REQ_PAL_WRITE) begin
          if (int'(palette_index_i) < PAL_DEPTH) begin
            pal_mem[palette_index_i] = palette_color_i;
          end
        end else begin
          colour_q.push_back(decode_pixel(pixel_bytes_i, pixel_column_i));
        end
      end
      // A stalled item stays put; otherwise the channel is free for the
      // next one, unless we are in a gap.
      if (!in_valid_i || !in_stall_o) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          nxt             = pending_q.pop_front();
          offer           = 1'b1;
          req_type_i      <= nxt.req;
          pixel_bytes_i   <= nxt.bytes;
          pixel_column_i  <= nxt.col;
          palette_index_i <= nxt.idx;
          palette_color_i <= nxt.colour;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= eager ? 0 : $urandom_range(0, 8);
          end
        end
        in_valid_i <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stalls on a pattern chosen per phase, and on request holds
  // off for a long stretch so that the pipeline fills and the input stalls.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen   <= hold_req_cnt;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (rx_mode)
        2'd0: out_stall_i <= 1'b0;
        2'd1: out_stall_i <= ($urandom_range(0, 2) == 0);
        2'd2: begin
          // A rotating pattern, reloaded now and then so that it drifts
          // against the sender's bursts.
          out_stall_i <= stall_pat[0];
          if ($urandom_range(0, 15) == 0) begin
            stall_pat <= 8'($urandom);
          end else begin
            stall_pat <= {stall_pat[0], stall_pat[7:1]};
          end
        end
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Output checker: each accepted result item is compared with the oldest
  // predicted colour.
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    argb_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (colour_q.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected, expected nothing, actual %02h%02h%02h%02h",
                 $time, alpha_out_o, red_out_o, green_out_o, blue_out_o);
      end else begin
        want = colour_q.pop_front();
        check_field("alpha", want.a, alpha_out_o);
        check_field("red",   want.r, red_out_o);
        check_field("green", want.g, green_out_o);
        check_field("blue",  want.b, blue_out_o);
      end
    end
  end

  // Watchdog: any handshake counts as progress; a long run of cycles without
  // one means the block has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_item(input logic req, input logic [31:0] bytes, input logic [2:0] col,
                           input logic [7:0] idx, input logic [31:0] colour);
    pixel_req_t it;
    it.req    = req;
    it.bytes  = bytes;
    it.col    = col;
    it.idx    = idx;
    it.colour = colour;
    pending_q.push_back(it);
  endtask

  task automatic push_decode(input logic [31:0] bytes, input logic [2:0] col);
    push_item(REQ_DECODE, bytes, col, 8'($urandom), $urandom);
  endtask

  task automatic push_pal_write(input logic [7:0] idx, input logic [31:0] colour);
    push_item(REQ_PAL_WRITE, $urandom, 3'($urandom), idx, colour);
  endtask

  // Waits until the sender has nothing left, every predicted colour has
  // arrived, and then long enough for a trailing palette write to land.
  // The check sits on the falling edge, where every update of the rising
  // edge has settled.
  task automatic settle();
    while (pending_q.size() != 0 || in_valid_i || colour_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Only called while the block is idle.
  task automatic write_format(input logic [3:0] fmt);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= fmt;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    fmt_cfg     = fmt;
    cfg_valid_i <= 1'b0;
  endtask

  // A phase of random traffic. Roughly a quarter of the items are palette
  // writes; under the palette formats the writes favour the entries that the
  // format can reach, and under 8 bpp some decodes read back the entry just
  // written.
  task automatic push_random_phase(input logic [3:0] fmt, input int count);
    pixel_req_t it;
    logic [7:0] last_idx;
    last_idx = '0;
    for (int k = 0; k < count; k++) begin
      it.req    = ($urandom_range(0, 3) == 0) ? REQ_PAL_WRITE : REQ_DECODE;
      it.bytes  = $urandom;
      it.col    = 3'($urandom_range(0, 7));
      it.idx    = 8'($urandom_range(0, 255));
      it.colour = $urandom;
      case ($urandom_range(0, 9))
        0:       it.bytes = '0;
        1:       it.bytes = '1;
        default: ;
      endcase
      if (it.req == REQ_PAL_WRITE) begin
        if (fmt == FMT_1BPP && $urandom_range(0, 1) == 0) begin
          it.idx = 8'($urandom_range(0, 1));
        end else if (fmt == FMT_4BPP && $urandom_range(0, 1) == 0) begin
          it.idx = 8'($urandom_range(0, 15));
        end
        last_idx = it.idx;
      end else if (fmt == FMT_8BPP && $urandom_range(0, 2) == 0) begin
        it.bytes[7:0] = last_idx;
      end
      pending_q.push_back(it);
    end
  endtask

  initial begin : stimulus
    logic [3:0] fmt;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    fmt_cfg = FMT_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. First the format left by reset, 32-bit ARGB, then a
    // palette filled at both ends of the index range.
    push_decode(32'h0000_0000, 3'd0);
    push_decode(32'hFFFF_FFFF, 3'd7);
    push_decode(32'h80A0_C0E0, 3'd3);
    push_pal_write(8'd0,   32'hFFFF_FFFF);
    push_pal_write(8'd1,   32'h0123_4567);
    push_pal_write(8'd15,  32'h89AB_CDEF);
    push_pal_write(8'd255, 32'hDEAD_BEEF);
    settle();

    // 1 bpp: the column picks the bit, most significant bit first.
    write_format(FMT_1BPP);
    push_decode(32'h0000_0001, 3'd7);
    push_decode(32'h0000_0080, 3'd0);
    push_decode(32'h0000_00FE, 3'd7);
    settle();

    // 4 bpp: even columns take the high nibble.
    write_format(FMT_4BPP);
    push_decode(32'h0000_00F0, 3'd0);
    push_decode(32'h0000_00F0, 3'd1);
    push_decode(32'h0000_000F, 3'd3);
    settle();

    // 8 bpp: the top entry, an entry never written (reads as zero), and a
    // write followed at once by a decode of the same entry.
    write_format(FMT_8BPP);
    push_decode(32'h0000_00FF, 3'd5);
    push_decode(32'h0000_0080, 3'd2);
    push_pal_write(8'h80, 32'h5A5A_A5A5);
    push_decode(32'h0000_0080, 3'd6);
    settle();

    write_format(FMT_ARGB1555);
    push_decode(32'h0000_FFFF, 3'd0);
    push_decode(32'hFFFF_0001, 3'd1);
    settle();

    // Grayscale 16 decodes to all zeros.
    write_format(FMT_GRAY16);
    push_decode(32'hFFFF_FFFF, 3'd4);
    settle();

    write_format(FMT_RGB555);
    push_decode(32'h0000_FFFF, 3'd2);
    settle();

    write_format(FMT_RGB565);
    push_decode(32'hFFFF_FFFF, 3'd0);
    push_decode(32'h0000_0841, 3'd7);
    settle();

    write_format(FMT_RGB24);
    push_decode(32'hFFFF_FFFF, 3'd1);
    settle();

    // The highest code is unassigned and decodes to all zeros.
    write_format(4'hF);
    push_decode(32'h1234_5678, 3'd0);
    settle();

    // Random part: twelve phases of about 34 items. The first nine walk
    // through every defined format; the rest pick any code, unassigned ones
    // included. Receiver behaviour and sender eagerness change per phase, so
    // some phases run with no idling at all.
    for (int p = 0; p < 12; p++) begin
      fmt = (p < 9) ? 4'(p) : 4'($urandom_range(0, 15));
      write_format(fmt);
      rx_mode <= 2'(p % 4);
      eager   <= (p % 3 == 0);
      // In one phase the receiver holds off for a long stretch while the
      // sender keeps offering, so the block fills and stalls its input.
      if (p == 5) begin
        rx_mode      <= 2'd0;
        eager        <= 1'b1;
        hold_req_cnt <= hold_req_cnt + 1;
      end
      push_random_phase(fmt, 34);
      settle();
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== pixel_format_decoder_with_palette_unit.f =====
src/pfd_pkg.sv
src/pixel_format_decoder_with_palette_unit.sv
tb/testbench.sv
